// ===== src/tgn_pkg.sv =====
// shared types, codes and neighbor offset tables for the tile grid neighbor generator
`timescale 1ns / 1ps
package tgn_pkg;

    // fixed field widths
    localparam int COORD_W     = 16;
    localparam int SLOT_W      = 3;
    localparam int SET_W       = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ORIENTATION    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STAGGER_AXIS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STAGGER_PARITY = 2'd2;

    // grid kinds
    localparam logic [1:0] ORIENT_ORTH = 2'd0;
    localparam logic [1:0] ORIENT_ISO  = 2'd1;
    localparam logic [1:0] ORIENT_STAG = 2'd2;
    localparam logic [1:0] ORIENT_HEX  = 2'd3;

    // neighbor set codes; hex codes are {1, axis, parity differs}
    localparam logic [SET_W-1:0] SET_ORTH      = 3'd0;
    localparam logic [SET_W-1:0] SET_ISO       = 3'd1;
    localparam logic [SET_W-1:0] SET_STAG_EVEN = 3'd2;
    localparam logic [SET_W-1:0] SET_STAG_ODD  = 3'd3;
    localparam logic [SET_W-1:0] SET_HEX_PM    = 3'd4;
    localparam logic [SET_W-1:0] SET_HEX_PD    = 3'd5;
    localparam logic [SET_W-1:0] SET_HEX_FM    = 3'd6;
    localparam logic [SET_W-1:0] SET_HEX_FD    = 3'd7;

    // final slot of each run length
    localparam logic [SLOT_W-1:0] LAST_SLOT_4 = 3'd3;
    localparam logic [SLOT_W-1:0] LAST_SLOT_6 = 3'd5;
    localparam logic [SLOT_W-1:0] LAST_SLOT_8 = 3'd7;
    localparam logic [SLOT_W-1:0] HEX_SLOTS   = 3'd6;

    typedef struct packed {
        logic [1:0] orientation;
        logic       stagger_axis;
        logic       stagger_parity;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SET_W-1:0]   set;
        logic [SLOT_W-1:0]  last_slot;
    } t_item;

    typedef struct packed {
        logic signed [2:0] dx;
        logic signed [2:0] dy;
    } t_offs;

    localparam t_offs TAB_ORTH [8] = '{
        '{3'sd0, -3'sd1}, '{3'sd0, 3'sd1}, '{-3'sd1, 3'sd0}, '{3'sd1, 3'sd0},
        '{3'sd1, -3'sd1}, '{3'sd1, 3'sd1}, '{-3'sd1, 3'sd1}, '{-3'sd1, -3'sd1}};

    localparam t_offs TAB_ISO [8] = '{
        '{-3'sd1, 3'sd0}, '{3'sd0, -3'sd1}, '{3'sd1, 3'sd0}, '{3'sd0, 3'sd1},
        '{-3'sd1, -3'sd1}, '{3'sd1, -3'sd1}, '{3'sd1, 3'sd1}, '{-3'sd1, 3'sd1}};

    localparam t_offs TAB_STAG_EVEN [4] = '{
        '{-3'sd1, -3'sd1}, '{3'sd0, -3'sd1}, '{3'sd0, 3'sd1}, '{-3'sd1, 3'sd1}};

    localparam t_offs TAB_STAG_ODD [4] = '{
        '{3'sd0, -3'sd1}, '{3'sd1, -3'sd1}, '{3'sd1, 3'sd1}, '{3'sd0, 3'sd1}};

    localparam t_offs TAB_STAG_DIAG [4] = '{
        '{3'sd0, -3'sd2}, '{3'sd1, 3'sd0}, '{3'sd0, 3'sd2}, '{-3'sd1, 3'sd0}};

    localparam t_offs TAB_HEX [4][6] = '{
        '{'{-3'sd1, -3'sd1}, '{3'sd0, -3'sd1}, '{3'sd1, 3'sd0},
          '{3'sd0, 3'sd1}, '{-3'sd1, 3'sd1}, '{-3'sd1, 3'sd0}},
        '{'{3'sd0, -3'sd1}, '{3'sd1, -3'sd1}, '{3'sd1, 3'sd0},
          '{3'sd1, 3'sd1}, '{3'sd0, 3'sd1}, '{-3'sd1, 3'sd0}},
        '{'{-3'sd1, -3'sd1}, '{3'sd0, -3'sd1}, '{3'sd1, -3'sd1},
          '{3'sd1, 3'sd0}, '{3'sd0, 3'sd1}, '{-3'sd1, 3'sd0}},
        '{'{-3'sd1, 3'sd0}, '{3'sd0, -3'sd1}, '{3'sd1, 3'sd0},
          '{3'sd1, 3'sd1}, '{3'sd0, 3'sd1}, '{-3'sd1, 3'sd1}}};

    // offset of one slot of one neighbor set
    function automatic t_offs nb_offset(input logic [SET_W-1:0] set,
                                        input logic [SLOT_W-1:0] slot);
        t_offs o;
        o = '{3'sd0, 3'sd0};
        unique case (set)
            SET_ORTH: o = TAB_ORTH[slot];
            SET_ISO:  o = TAB_ISO[slot];
            SET_STAG_EVEN, SET_STAG_ODD: begin
                if (slot[2]) begin
                    o = TAB_STAG_DIAG[slot[1:0]];
                end else if (set == SET_STAG_EVEN) begin
                    o = TAB_STAG_EVEN[slot[1:0]];
                end else begin
                    o = TAB_STAG_ODD[slot[1:0]];
                end
            end
            SET_HEX_PM, SET_HEX_PD, SET_HEX_FM, SET_HEX_FD: begin
                if (slot < HEX_SLOTS) begin
                    o = TAB_HEX[set[1:0]][slot];
                end
            end
        endcase
        return o;
    endfunction

endpackage

// ===== src/tgn_front.sv =====
// front end: takes a tile request and picks its neighbor set and run length
`timescale 1ns / 1ps
module tgn_front #(
    parameter int CW_INT = 16
) (
    input  tgn_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tgn_pkg::COORD_W-1:0]  i_tile_x,
    input  logic [tgn_pkg::COORD_W-1:0]  i_tile_y,
    input  logic                         i_diagonals,
    output logic                         o_push,
    input  logic                         i_push_ready,
    output tgn_pkg::t_item               o_item
);

    logic [CW_INT-1:0] x_c;
    logic [CW_INT-1:0] y_c;
    logic              par;

    assign x_c = i_tile_x[CW_INT-1:0];
    assign y_c = i_tile_y[CW_INT-1:0];
    assign par = i_cfg.stagger_axis ? x_c[0] : y_c[0];

    assign o_ready = i_push_ready;
    assign o_push  = i_valid && i_push_ready;

    always_comb begin
        o_item   = '0;
        o_item.x = tgn_pkg::COORD_W'(x_c);
        o_item.y = tgn_pkg::COORD_W'(y_c);
        unique case (i_cfg.orientation)
            tgn_pkg::ORIENT_ORTH: begin
                o_item.set       = tgn_pkg::SET_ORTH;
                o_item.last_slot = i_diagonals ? tgn_pkg::LAST_SLOT_8 : tgn_pkg::LAST_SLOT_4;
            end
            tgn_pkg::ORIENT_ISO: begin
                o_item.set       = tgn_pkg::SET_ISO;
                o_item.last_slot = i_diagonals ? tgn_pkg::LAST_SLOT_8 : tgn_pkg::LAST_SLOT_4;
            end
            tgn_pkg::ORIENT_STAG: begin
                o_item.set       = y_c[0] ? tgn_pkg::SET_STAG_ODD : tgn_pkg::SET_STAG_EVEN;
                o_item.last_slot = i_diagonals ? tgn_pkg::LAST_SLOT_8 : tgn_pkg::LAST_SLOT_4;
            end
            tgn_pkg::ORIENT_HEX: begin
                // hex code carries axis and parity mismatch in its low bits
                o_item.set       = {1'b1, i_cfg.stagger_axis, par != i_cfg.stagger_parity};
                o_item.last_slot = tgn_pkg::LAST_SLOT_6;
            end
        endcase
    end

endmodule

// ===== src/tgn_queue.sv =====
// small register fifo between the front end and the emitter
`timescale 1ns / 1ps
module tgn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  tgn_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output tgn_pkg::t_item o_item
);

    localparam int PTR_W = $clog2(tgn_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tgn_pkg::QUEUE_DEPTH + 1);

    tgn_pkg::t_item   r_mem [tgn_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_count != CNT_W'(tgn_pkg::QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(tgn_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(tgn_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/tgn_back.sv =====
// emitter: walks the slots of the head item and drives the output register
`timescale 1ns / 1ps
module tgn_back #(
    parameter int CW_INT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  tgn_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tgn_pkg::COORD_W-1:0]   o_nx,
    output logic [tgn_pkg::COORD_W-1:0]   o_ny,
    output logic [tgn_pkg::SLOT_W-1:0]    o_slot,
    output logic                          o_last
);

    logic [tgn_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic                        r_out_valid, n_out_valid;
    logic [tgn_pkg::COORD_W-1:0] r_nx, r_ny;
    logic [tgn_pkg::SLOT_W-1:0]  r_out_slot;
    logic                        r_out_last;

    tgn_pkg::t_offs    off;
    logic [CW_INT-1:0] dx_e, dy_e;
    logic [CW_INT-1:0] sum_x, sum_y;
    logic              step;
    logic              at_last;

    assign off     = tgn_pkg::nb_offset(i_item.set, r_slot);
    assign dx_e    = CW_INT'(off.dx);
    assign dy_e    = CW_INT'(off.dy);
    assign sum_x   = i_item.x[CW_INT-1:0] + dx_e;
    assign sum_y   = i_item.y[CW_INT-1:0] + dy_e;
    assign step    = i_valid && (!r_out_valid || i_ready);
    assign at_last = (r_slot == i_item.last_slot);
    assign o_pop   = step && at_last;

    always_comb begin
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
            n_slot      = at_last ? '0 : r_slot + 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_nx       <= tgn_pkg::COORD_W'(sum_x);
            r_ny       <= tgn_pkg::COORD_W'(sum_y);
            r_out_slot <= r_slot;
            r_out_last <= at_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_slot  = r_out_slot;
    assign o_last  = r_out_last;

endmodule

// ===== src/tile_grid_neighbor_generator_top.sv =====
// top level of the tile grid neighbor generator
`timescale 1ns / 1ps
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tile_x, tile_y, diagonals
//  m_axis    out  m_axis_tvalid / m_axis_tready  neighbor_x, neighbor_y, slot; last on tlast
//  cfg       in   i_cfg_we                       register index, data
//
//  one request word yields 4, 6 or 8 result words, one word per cycle from the emitter
//  slot counter while the output is not stalled; the queue entry pops with its last slot
//  a taken request is written to the queue, then its first word enters the output register
//  a two-entry queue lets the input side take requests while the emitter is busy
//  or while the output register is stalled; s_axis_tready drops only when it is full
//  synchronous active-low reset empties the queue and output; config registers go to zero
module tile_grid_neighbor_generator_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [tgn_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tgn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tgn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // tile_x, tile_y, diagonals
    // result words
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tgn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // neighbor_x, neighbor_y, slot
    output logic                               m_axis_tlast
);

    // coordinates above 16 bits wrap the same as 16-bit ones once masked to the port
    localparam int CW_INT = (COORD_WIDTH < tgn_pkg::COORD_W) ? COORD_WIDTH : tgn_pkg::COORD_W;

    localparam int CW = tgn_pkg::COORD_W;

    tgn_pkg::t_cfg  r_cfg;
    tgn_pkg::t_item front_item;
    tgn_pkg::t_item queue_item;
    logic           push;
    logic           push_ready;
    logic           queue_valid;
    logic           pop;

    logic [CW-1:0]                  nx, ny;
    logic [tgn_pkg::SLOT_W-1:0]     slot;

    // config registers, out-of-range index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tgn_pkg::REG_ORIENTATION:    r_cfg.orientation    <= i_cfg_data[1:0];
                tgn_pkg::REG_STAGGER_AXIS:   r_cfg.stagger_axis   <= i_cfg_data[0];
                tgn_pkg::REG_STAGGER_PARITY: r_cfg.stagger_parity <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tgn_front #(.CW_INT(CW_INT)) u_front (
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_tile_x     (s_axis_tdata[CW-1:0]),
        .i_tile_y     (s_axis_tdata[2*CW-1:CW]),
        .i_diagonals  (s_axis_tdata[2*CW]),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_item       (front_item)
    );

    tgn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_item       (front_item),
        .o_valid      (queue_valid),
        .i_pop        (pop),
        .o_item       (queue_item)
    );

    tgn_back #(.CW_INT(CW_INT)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_nx    (nx),
        .o_ny    (ny),
        .o_slot  (slot),
        .o_last  (m_axis_tlast)
    );

    // pack result word, zero padding on top
    assign m_axis_tdata = {
        (tgn_pkg::OUT_TDATA_W - 2*CW - tgn_pkg::SLOT_W)'(0), slot, ny, nx};

endmodule

// ===== src/tgn_checker.sv =====
// port-level checker for the tile grid neighbor generator and its bind
`timescale 1ns / 1ps
module tgn_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tgn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    localparam int SLOT_LO = 2 * tgn_pkg::COORD_W;

    logic [tgn_pkg::SLOT_W-1:0] slot;
    logic                       out_take;

    assign slot     = m_axis_tdata[SLOT_LO + tgn_pkg::SLOT_W - 1:SLOT_LO];
    assign out_take = m_axis_tvalid && m_axis_tready;

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // runs end only after 4, 6 or 8 words
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            slot == tgn_pkg::LAST_SLOT_4 || slot == tgn_pkg::LAST_SLOT_6 ||
            slot == tgn_pkg::LAST_SLOT_8)
        else $error("last word on a bad slot");

    // slots count up within a run
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(out_take) && !$past(m_axis_tlast) && m_axis_tvalid |->
            slot == $past(slot) + 1'b1)
        else $error("slot did not advance");

    // a new run starts at slot zero
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(out_take) && $past(m_axis_tlast) && m_axis_tvalid |->
            slot == '0)
        else $error("run did not start at slot zero");

endmodule

bind tile_grid_neighbor_generator_top tgn_checker u_tgn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/tb_tile_grid_neighbor_generator_top.sv =====
// self-checking testbench for the tile grid neighbor generator top level
`timescale 1ns / 1ps
module tb_tile_grid_neighbor_generator_top;

    // run bounds
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TILES_PER_SET = 34;
    localparam int TRAIL_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;

    // index past the last register, writes to it must be dropped
    localparam logic [tgn_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    // one request word and one result word as fields
    typedef struct {
        logic [tgn_pkg::COORD_W-1:0] x;
        logic [tgn_pkg::COORD_W-1:0] y;
        logic                        diag;
    } t_tile_req;

    typedef struct {
        logic [tgn_pkg::COORD_W-1:0] x;
        logic [tgn_pkg::COORD_W-1:0] y;
        logic [tgn_pkg::SLOT_W-1:0]  slot;
        logic                        last;
    } t_neighbor;

    // dut ports, all inputs known from time zero
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [tgn_pkg::CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [tgn_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tgn_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // tile_x, tile_y, diagonals
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tgn_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // neighbor_x, neighbor_y, slot
    logic                            m_axis_tlast;

    // neighbor offsets per grid kind, in emitted order
    int orth_dx [8] = '{0, 0, -1, 1, 1, 1, -1, -1};
    int orth_dy [8] = '{-1, 1, 0, 0, -1, 1, 1, -1};
    int iso_dx  [8] = '{-1, 0, 1, 0, -1, 1, 1, -1};
    int iso_dy  [8] = '{0, -1, 0, 1, -1, -1, 1, 1};
    int stag_even_dx [4] = '{-1, 0, 0, -1};
    int stag_even_dy [4] = '{-1, -1, 1, 1};
    int stag_odd_dx  [4] = '{0, 1, 1, 0};
    int stag_odd_dy  [4] = '{-1, -1, 1, 1};
    int stag_diag_dx [4] = '{0, 1, 0, -1};
    int stag_diag_dy [4] = '{-2, 0, 2, 0};
    // hex rows: pointy matching, pointy differing, flat matching, flat differing
    int hex_dx [4][6] = '{'{-1, 0, 1, 0, -1, -1}, '{0, 1, 1, 1, 0, -1},
                          '{-1, 0, 1, 1, 0, -1}, '{-1, 0, 1, 1, 0, -1}};
    int hex_dy [4][6] = '{'{-1, -1, 0, 1, 1, 0}, '{-1, -1, 0, 1, 1, 0},
                          '{-1, -1, -1, 0, 1, 0}, '{0, -1, 0, 1, 1, 1}};

    // shadow copy of the grid registers
    logic [1:0] grid_kind = tgn_pkg::ORIENT_ORTH;
    logic       grid_axis = 1'b0;
    logic       grid_parity = 1'b0;

    t_tile_req tile_requests[$];       // waiting to be offered
    t_neighbor expected_neighbors[$];  // predicted, not yet seen
    t_tile_req offered_tile;

    int send_idle_pct = 7;
    int recv_idle_pct = 76;
    int cycle_count = 0;
    int tiles_taken = 0;
    int neighbors_seen = 0;
    int mismatch_count = 0;

    tile_grid_neighbor_generator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // expected neighbor words of one tile under the current registers
    function automatic void predict_neighbors(input t_tile_req t);
        int        count;
        int        hex_row;
        int        dx;
        int        dy;
        logic      stag_coord_odd;
        t_neighbor n;
        hex_row = 0;
        if (grid_kind == tgn_pkg::ORIENT_HEX) begin
            // pointy grids stagger on rows, flat grids on columns
            stag_coord_odd = grid_axis ? t.x[0] : t.y[0];
            hex_row = 2 * int'(grid_axis) + int'(stag_coord_odd != grid_parity);
            count = 6;
        end else begin
            count = t.diag ? 8 : 4;
        end
        for (int k = 0; k < count; k++) begin
            case (grid_kind)
                tgn_pkg::ORIENT_ORTH: begin
                    dx = orth_dx[k];
                    dy = orth_dy[k];
                end
                tgn_pkg::ORIENT_ISO: begin
                    dx = iso_dx[k];
                    dy = iso_dy[k];
                end
                tgn_pkg::ORIENT_STAG: begin
                    // axis and parity play no part here, only the row parity
                    if (k >= 4) begin
                        dx = stag_diag_dx[k - 4];
                        dy = stag_diag_dy[k - 4];
                    end else if (!t.y[0]) begin
                        dx = stag_even_dx[k];
                        dy = stag_even_dy[k];
                    end else begin
                        dx = stag_odd_dx[k];
                        dy = stag_odd_dy[k];
                    end
                end
                default: begin
                    dx = hex_dx[hex_row][k];
                    dy = hex_dy[hex_row][k];
                end
            endcase
            // coordinates wrap at the field width
            n.x    = t.x + tgn_pkg::COORD_W'(dx);
            n.y    = t.y + tgn_pkg::COORD_W'(dy);
            n.slot = tgn_pkg::SLOT_W'(k);
            n.last = (k == count - 1);
            expected_neighbors = {expected_neighbors, n};
        end
    endfunction

    // compare one result word against the oldest prediction
    function automatic void check_neighbor();
        t_neighbor got;
        t_neighbor want;
        got.x    = m_axis_tdata[tgn_pkg::COORD_W-1:0];
        got.y    = m_axis_tdata[2*tgn_pkg::COORD_W-1:tgn_pkg::COORD_W];
        got.slot = m_axis_tdata[2*tgn_pkg::COORD_W+tgn_pkg::SLOT_W-1:2*tgn_pkg::COORD_W];
        got.last = m_axis_tlast;
        neighbors_seen++;
        if (expected_neighbors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("t=%0t unexpected neighbor word x=%h y=%h slot=%0d last=%0b",
                         $realtime, got.x, got.y, got.slot, got.last);
            return;
        end
        want = expected_neighbors.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.slot !== want.slot ||
            got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("t=%0t neighbor mismatch: want x=%h y=%h slot=%0d last=%0b",
                         $realtime, want.x, want.y, want.slot, want.last);
                $display("    got x=%h y=%h slot=%0d last=%0b",
                         got.x, got.y, got.slot, got.last);
            end
        end
    endfunction

    // request driver: offers the next queued tile unless it idles this cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_neighbors(offered_tile);
                tiles_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tile_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_tile = tile_requests.pop_front();
                    s_axis_tdata <= {7'd0, offered_tile.diag, offered_tile.y, offered_tile.x};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_neighbor();
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d neighbor words still awaited",
                     cycle_count, expected_neighbors.size());
            $display("[tile_grid_neighbor_generator_top] ERROR");
            $finish;
        end
    end

    // one register write, mirrored into the shadow copy
    task automatic program_register(input logic [tgn_pkg::CFG_ADDR_W-1:0] index,
                                    input logic [tgn_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            tgn_pkg::REG_ORIENTATION:    grid_kind = value;
            tgn_pkg::REG_STAGGER_AXIS:   grid_axis = value[0];
            tgn_pkg::REG_STAGGER_PARITY: grid_parity = value[0];
            default: ;
        endcase
    endtask

    // block until no tile is pending and every neighbor word has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tile_requests.size() != 0 || s_axis_tvalid || expected_neighbors.size() != 0);
    endtask

    task automatic queue_tile(input logic [tgn_pkg::COORD_W-1:0] x,
                              input logic [tgn_pkg::COORD_W-1:0] y,
                              input logic diag);
        t_tile_req t;
        t.x = x;
        t.y = y;
        t.diag = diag;
        tile_requests = {tile_requests, t};
    endtask

    // random coordinate, biased toward the wrap points
    function automatic logic [tgn_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return tgn_pkg::COORD_W'(1);
            3: return tgn_pkg::COORD_W'({tgn_pkg::COORD_W{1'b1}} - 1);
            default: return tgn_pkg::COORD_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [1:0] kind;
        logic       axis;
        logic       parity;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: orth, iso, staggered (axis and parity set, must be ignored)
        // and the four hex variants, each on corner tiles with both diagonal settings
        for (int s = 0; s < 7; s++) begin
            wait_idle();
            kind   = (s < 3) ? 2'(s) : tgn_pkg::ORIENT_HEX;
            axis   = (s < 3) ? (s == 2) : 1'((s - 3) >> 1);
            parity = (s < 3) ? (s == 2) : 1'(s - 3);
            program_register(tgn_pkg::REG_ORIENTATION, kind);
            program_register(tgn_pkg::REG_STAGGER_AXIS, {1'b0, axis});
            program_register(tgn_pkg::REG_STAGGER_PARITY, {1'b0, parity});
            // writes past the register file are dropped
            program_register(REG_UNUSED, 2'($urandom_range(3)));
            @(negedge i_clk);
            queue_tile('0, '0, 1'b1);
            queue_tile('1, '1, 1'b1);
            queue_tile(tgn_pkg::COORD_W'(1),
                       tgn_pkg::COORD_W'({tgn_pkg::COORD_W{1'b1}} - 1), 1'b0);
        end

        // random: three idling profiles, each sweeping every grid kind once
        for (int mode = 0; mode < 3; mode++) begin
            for (int ph = 0; ph < 4; ph++) begin
                wait_idle();
                case (mode)
                    0: begin
                        send_idle_pct = 7;
                        recv_idle_pct = 76;
                    end
                    1: begin
                        send_idle_pct = 76;
                        recv_idle_pct = 7;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                program_register(tgn_pkg::REG_STAGGER_AXIS, 2'($urandom_range(3)));
                program_register(tgn_pkg::REG_STAGGER_PARITY, 2'($urandom_range(3)));
                if ($urandom_range(1))
                    program_register(REG_UNUSED, 2'($urandom_range(3)));
                program_register(tgn_pkg::REG_ORIENTATION, 2'(ph));
                @(negedge i_clk);
                for (int n = 0; n < TILES_PER_SET; n++)
                    queue_tile(pick_coord(), pick_coord(), 1'($urandom_range(1)));
            end
        end

        // drain, then watch a little longer for stray words
        wait_idle();
        repeat (TRAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d tile requests across all four grid kinds and hex variants,",
                 tiles_taken);
        $display("with %0d neighbor words checked and %0d mismatches", neighbors_seen,
                 mismatch_count);
        if (mismatch_count == 0 && expected_neighbors.size() == 0) begin
            $display("[tile_grid_neighbor_generator_top] OK");
        end else begin
            $display("[tile_grid_neighbor_generator_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tgn_pkg.sv
src/tgn_front.sv
src/tgn_queue.sv
src/tgn_back.sv
src/tile_grid_neighbor_generator_top.sv
src/tgn_checker.sv
verif/tb_tile_grid_neighbor_generator_top.sv
